// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file tbc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tbc_pkg.sv =====
package tbc_pkg;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		PH_OUTSIDE,
		PH_AFTER_LT,
		PH_SKIP,
		PH_AFTER_SLASH
	} phase_t;

	typedef enum logic [2:0] {
		V_OK       = 3'd0,
		V_MISMATCH = 3'd1,
		V_EMPTY    = 3'd2,
		V_UNCLOSED = 3'd3,
		V_OVERFLOW = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP
	} stk_op_t;

	typedef struct packed {
		stk_op_t    op;
		logic [7:0] letter;
	} stk_ctrl_t;

	typedef struct packed {
		logic     valid;
		verdict_t verdict;
	} result_t;

	function automatic logic is_letter(input logic [7:0] c);
		logic up;
		logic lo;
		up = (c >= 8'h41) && (c <= 8'h5A);
		lo = (c >= 8'h61) && (c <= 8'h7A);
		return up || lo;
	endfunction

endpackage

// ===== rtl/tbc_char_if.sv =====
interface tbc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source(output valid, output char_in, output is_last, input ready);
	modport sink(input valid, input char_in, input is_last, output ready);
endinterface

// ===== rtl/tbc_verdict_if.sv =====
interface tbc_verdict_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;

	modport source(output valid, output verdict, input ready);
	modport sink(input valid, input verdict, output ready);
endinterface

// ===== rtl/tag_balance_checker_top.sv =====
// Tag nesting checker for a character stream.
// in_ch carries one character (char_in) and an end-of-text mark (is_last) per
// transaction; out_ch carries one verdict per text: 0 balanced, 1 mismatch,
// 2 close on empty stack, 3 unclosed tags, 4 overflow. The first error wins.
// Throughput: one character per cycle while in_ch.ready is high. The open-tag
// letters sit in a row of STACK_DEPTH cells that shift down on a push and up
// on a pop, so the top letter is always in the first cell. The verdict is formed
// from the last character as it is taken and is registered for out_ch.
// A stalled receiver: the verdict waits in the output register; a second
// verdict goes to a one-entry skid register, and in_ch.ready drops only while
// that skid register is full. Characters without a verdict keep flowing.
// Reset clears the parse phase, level, error latch and output valids; the
// cell contents are not cleared, since a cell is read only after a push.
// After each last character the block starts a fresh text.
module tag_balance_checker_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tbc_char_if.sink             in_ch,
	tbc_verdict_if.source        out_ch
);

	tbc_pkg::stk_ctrl_t stk;
	tbc_pkg::result_t   res;
	logic [7:0]         cell_q [STACK_DEPTH];
	logic               fire;
	logic               out_valid_q, skid_valid_q;
	tbc_pkg::verdict_t  out_data_q, skid_data_q;

	assign in_ch.ready = !skid_valid_q;
	assign fire        = in_ch.valid && in_ch.ready;

	tbc_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.char_in    (in_ch.char_in),
		.is_last    (in_ch.is_last),
		.top_letter (cell_q[0]),
		.stk        (stk),
		.res        (res)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [7:0] up_data;
		logic [7:0] down_data;
		if (i == 0) begin : g_head
			assign up_data = stk.letter;
		end else begin : g_body
			assign up_data = cell_q[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign down_data = cell_q[i];
		end else begin : g_link
			assign down_data = cell_q[i+1];
		end
		tbc_cell u_cell (
			.clk       (clk),
			.op        (stk.op),
			.up_data   (up_data),
			.down_data (down_data),
			.q         (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res.valid;
			end
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ch.ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : res.verdict;
		end else if (res.valid) begin
			skid_data_q <= res.verdict;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.verdict = out_data_q;

endmodule

// ===== rtl/tbc_cell.sv =====
module tbc_cell (
	input  logic             clk,
	input  tbc_pkg::stk_op_t op,
	input  logic [7:0]       up_data,
	input  logic [7:0]       down_data,
	output logic [7:0]       q
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			tbc_pkg::STK_PUSH: data_q <= up_data;
			tbc_pkg::STK_POP:  data_q <= down_data;
			default:           data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

// ===== rtl/tbc_ctrl.sv =====
module tbc_ctrl #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          char_in,
	input  logic                is_last,
	input  logic [7:0]          top_letter,
	output tbc_pkg::stk_ctrl_t  stk,
	output tbc_pkg::result_t    res
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);

	tbc_pkg::phase_t   phase_q, phase_d;
	tbc_pkg::verdict_t err_q, err_d;
	logic [LVL_W-1:0]  level_q, level_d;
	tbc_pkg::phase_t   phase_n;
	tbc_pkg::verdict_t err_n;
	logic [LVL_W-1:0]  level_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tbc_pkg::PH_OUTSIDE;
			err_q   <= tbc_pkg::V_OK;
			level_q <= '0;
		end else begin
			phase_q <= phase_d;
			err_q   <= err_d;
			level_q <= level_d;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		err_n      = err_q;
		level_n    = level_q;
		stk.op     = tbc_pkg::STK_HOLD;
		stk.letter = char_in;
		unique case (phase_q)
			tbc_pkg::PH_OUTSIDE: begin
				if (char_in == tbc_pkg::CH_LT) phase_n = tbc_pkg::PH_AFTER_LT;
			end
			tbc_pkg::PH_AFTER_LT: begin
				priority if (tbc_pkg::is_letter(char_in)) begin
					phase_n = tbc_pkg::PH_SKIP;
					if (level_q == LVL_W'(STACK_DEPTH)) begin
						if (err_q == tbc_pkg::V_OK) err_n = tbc_pkg::V_OVERFLOW;
					end else begin
						stk.op  = tbc_pkg::STK_PUSH;
						level_n = level_q + 1'b1;
					end
				end else if (char_in == tbc_pkg::CH_SLASH) begin
					phase_n = tbc_pkg::PH_AFTER_SLASH;
				end else if (char_in == tbc_pkg::CH_LT) begin
					phase_n = tbc_pkg::PH_AFTER_LT;
				end else begin
					phase_n = tbc_pkg::PH_OUTSIDE;
				end
			end
			tbc_pkg::PH_SKIP: begin
				if (char_in == tbc_pkg::CH_GT) phase_n = tbc_pkg::PH_OUTSIDE;
			end
			default: begin
				phase_n = (char_in == tbc_pkg::CH_GT) ? tbc_pkg::PH_OUTSIDE
					: tbc_pkg::PH_SKIP;
				if (level_q == '0) begin
					if (err_q == tbc_pkg::V_OK) err_n = tbc_pkg::V_EMPTY;
				end else begin
					stk.op  = tbc_pkg::STK_POP;
					level_n = level_q - 1'b1;
					if (top_letter != char_in && err_q == tbc_pkg::V_OK)
						err_n = tbc_pkg::V_MISMATCH;
				end
			end
		endcase

		priority if (err_n != tbc_pkg::V_OK) res.verdict = err_n;
		else if (level_n != '0)               res.verdict = tbc_pkg::V_UNCLOSED;
		else                                  res.verdict = tbc_pkg::V_OK;
		res.valid = fire && is_last;

		if (!fire) begin
			stk.op  = tbc_pkg::STK_HOLD;
			phase_d = phase_q;
			err_d   = err_q;
			level_d = level_q;
		end else if (is_last) begin
			phase_d = tbc_pkg::PH_OUTSIDE;
			err_d   = tbc_pkg::V_OK;
			level_d = '0;
		end else begin
			phase_d = phase_n;
			err_d   = err_n;
			level_d = level_n;
		end
	end

endmodule

// ===== rtl/tbc_checker.sv =====
`include "assert_macros.svh"

module tbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] verdict
);

	logic in_fire;
	logic last_fire;
	logic mid_fire;
	logic stall;

	assign in_fire   = in_valid && in_ready;
	assign last_fire = in_fire && in_is_last;
	assign mid_fire  = in_fire && !in_is_last;
	assign stall     = out_valid && !out_ready;

	`TBC_ASSERT_NXT(a_out_hold, stall, out_valid && $stable(verdict), "verdict not held")
	`TBC_ASSERT_NOW(a_verdict_code, out_valid, verdict <= tbc_pkg::V_OVERFLOW, "bad code")
	`TBC_ASSERT_NOW(a_rise_on_last, $rose(out_valid), $past(last_fire), "no last char")
	`TBC_ASSERT_NXT(a_no_spurious, mid_fire && !out_valid, !out_valid, "spurious verdict")

endmodule

bind tag_balance_checker_top tbc_checker u_tbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_is_last (in_ch.is_last),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.verdict    (out_ch.verdict)
);
